### src/dpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared widths and control types for the dot product and distance block.
// ----------------------------------------------------------------------------
package dpd_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int ELEM_W    = 16;
    localparam int MUL_W     = 2 * ELEM_W;
    localparam int DIFF_W    = ELEM_W + 1;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int PROD_W    = 42;
    localparam int SQ_SUM_W  = 43;
    localparam int ROOT_W    = 22;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int COUNT_W   = $clog2(MAX_LEN + 1);
    localparam int STEP_W    = $clog2(ROOT_W + 1);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;      // request accepted this cycle
        logic start;     // close the sums and seed the square root
        logic step;      // one square-root digit
        logic load_out;  // move the finished result into the output register
    } dpd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic root_done;
        logic out_free;
    } dpd_stat_t;

endpackage

### src/dpd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_ctrl
// Sequencer: accumulate pairs, drain the last one, run the root, hand off.
// ----------------------------------------------------------------------------
module dpd_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    input  dpd_pkg::dpd_stat_t stat,
    output dpd_pkg::dpd_cmd_t  cmd
);
    import dpd_pkg::*;

    typedef enum logic [3:0] {
        S_ACC   = 4'b0001,
        S_DRAIN = 4'b0010,
        S_ROOT  = 4'b0100,
        S_LOAD  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            S_ACC:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cmd.start  = 1'b1;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (stat.root_done)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_LOAD:
            begin
                // hold until the previous result has left
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

endmodule

### src/dpd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_datapath
// Product and squared-difference stage, two accumulators, a bit-serial
// integer square root and the output register.
// ----------------------------------------------------------------------------
module dpd_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dpd_pkg::dpd_cmd_t                     cmd,
    input  logic signed [dpd_pkg::ELEM_W-1:0]     x_element,
    input  logic signed [dpd_pkg::ELEM_W-1:0]     y_element,
    input  logic                                  last,
    output dpd_pkg::dpd_stat_t                    stat,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [dpd_pkg::PROD_W-1:0]     dot_product,
    output logic        [dpd_pkg::ROOT_W-1:0]     distance,
    output logic                                  too_long
);
    import dpd_pkg::*;

    // request stage
    logic signed [MUL_W-1:0]  prod_c;
    logic signed [DIFF_W-1:0] diff_c;
    logic signed [SQ_W-1:0]   sq_c;
    logic                     room_c;

    logic signed [MUL_W-1:0]  prod1_reg;
    logic        [SQ_W-1:0]   sq1_reg;
    logic                     take1_reg;
    logic                     flag1_reg;

    logic [COUNT_W-1:0]       count_reg;
    logic                     over_reg;

    // accumulators
    logic [PROD_W-1:0]        prod_sum_reg;
    logic [SQ_SUM_W-1:0]      sq_sum_reg;
    logic [PROD_W-1:0]        prod_term_c;
    logic [SQ_SUM_W-1:0]      sq_term_c;
    logic [PROD_W-1:0]        prod_sum_next;
    logic [SQ_SUM_W-1:0]      sq_sum_next;

    // square root
    logic [RAD_W-1:0]         rad_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [PROD_W-1:0]        dot_hold_reg;
    logic                     flag_hold_reg;
    logic [REM_W-1:0]         rem_shift_c;
    logic [REM_W-1:0]         trial_c;
    logic                     fits_c;

    // output register
    logic                     out_valid_reg;
    logic [PROD_W-1:0]        dot_out_reg;
    logic [ROOT_W-1:0]        dist_out_reg;
    logic                     too_long_out_reg;

    assign prod_c = x_element * y_element;
    assign diff_c = DIFF_W'(x_element) - DIFF_W'(y_element);
    assign sq_c   = diff_c * diff_c;
    assign room_c = (count_reg < COUNT_W'(MAX_LEN));

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            prod1_reg <= prod_c;
            sq1_reg   <= sq_c;
            flag1_reg <= over_reg | ~room_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            take1_reg <= 1'b0;
            count_reg <= '0;
            over_reg  <= 1'b0;
        end
        else
        begin
            take1_reg <= cmd.take & room_c;
            if (cmd.take)
            begin
                if (last)
                begin
                    count_reg <= '0;
                    over_reg  <= 1'b0;
                end
                else if (room_c)
                begin
                    count_reg <= count_reg + COUNT_W'(1);
                end
                else
                begin
                    over_reg <= 1'b1;
                end
            end
        end
    end

    assign prod_term_c   = take1_reg ? {{(PROD_W - MUL_W){prod1_reg[MUL_W-1]}}, prod1_reg}
                                     : '0;
    assign sq_term_c     = take1_reg ? {{(SQ_SUM_W - SQ_W){1'b0}}, sq1_reg} : '0;
    assign prod_sum_next = prod_sum_reg + prod_term_c;
    assign sq_sum_next   = sq_sum_reg + sq_term_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_sum_reg <= '0;
            sq_sum_reg   <= '0;
        end
        else if (cmd.start)
        begin
            prod_sum_reg <= '0;
            sq_sum_reg   <= '0;
        end
        else
        begin
            prod_sum_reg <= prod_sum_next;
            sq_sum_reg   <= sq_sum_next;
        end
    end

    // one root bit per step, two radicand bits shifted in
    assign rem_shift_c = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial_c     = {root_reg, 2'b01};
    assign fits_c      = (rem_shift_c >= trial_c);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rad_reg       <= {{(RAD_W - SQ_SUM_W){1'b0}}, sq_sum_next};
            rem_reg       <= '0;
            root_reg      <= '0;
            dot_hold_reg  <= prod_sum_next;
            flag_hold_reg <= flag1_reg;
        end
        else if (cmd.step)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits_c ? (rem_shift_c - trial_c) : rem_shift_c;
            root_reg <= {root_reg[ROOT_W-2:0], fits_c};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.start)
        begin
            step_reg <= '0;
        end
        else if (cmd.step)
        begin
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            dot_out_reg      <= dot_hold_reg;
            dist_out_reg     <= root_reg;
            too_long_out_reg <= flag_hold_reg;
        end
    end

    assign stat.root_done = (step_reg == STEP_W'(ROOT_W));
    assign stat.out_free  = ~out_valid_reg | out_ready;

    assign out_valid   = out_valid_reg;
    assign dot_product = dot_out_reg;
    assign distance    = dist_out_reg;
    assign too_long    = too_long_out_reg;

endmodule

### src/dot_product_and_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dot_product_and_distance
// Streamed dot product and Euclidean distance of two Q7.8 vectors.
//
//   Channel   Dir  Handshake                    Payload
//   s_axis    in   s_axis_tvalid/tready/tlast   x_element, y_element
//   m_axis    out  m_axis_tvalid/tready         dot_product, distance, too_long
//
// One pair is taken per cycle while accumulating. After the pair marked last
// the input stalls while the sums are closed, the 22 digit steps of the
// bit-serial square root run and finish, and the result is loaded into the output
// register; the stall lasts longer if the previous result has not been taken yet.
// Reset clears the sums, the pair count and the handshake state.
// A waiting result does not block the next vector from accumulating.
// ----------------------------------------------------------------------------
module dot_product_and_distance
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // x_element [15:0], y_element [31:16]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // dot_product [41:0], distance [63:42]
    output logic        m_axis_tuser    // too_long [0]
);
    import dpd_pkg::*;

    dpd_cmd_t                 cmd;
    dpd_stat_t                stat;
    logic signed [PROD_W-1:0] dot_product;
    logic [ROOT_W-1:0]        distance;
    logic                     too_long;

    dpd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dpd_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .x_element   (s_axis_tdata[ELEM_W-1:0]),
        .y_element   (s_axis_tdata[2*ELEM_W-1:ELEM_W]),
        .last        (s_axis_tlast),
        .stat        (stat),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .dot_product (dot_product),
        .distance    (distance),
        .too_long    (too_long)
    );

    assign m_axis_tdata = {distance, dot_product};
    assign m_axis_tuser = too_long;

endmodule
